FILE: hw/rtl/rws_pkg.sv
package rws_pkg;

  localparam int MAX_POPULATION = 64;
  localparam int MAG_W = 31;
  localparam int POP_W = 7;
  localparam logic [POP_W-1:0] POP_RESET = 7'd50;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [5:0]         entry_index;
    logic signed [31:0] fitness_value;
    logic [15:0]        random_fraction;
  } in_beat_t;

  typedef struct packed {
    logic [5:0] selected_index;
    logic       total_is_zero;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_UPD,
    ST_SEL_MUL,
    ST_SEL_WALK,
    ST_DONE
  } eng_state_t;

endpackage

FILE: hw/rtl/rws_fit_ram.sv
module rws_fit_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 31
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/rws_engine.sv
module rws_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rws_pkg::in_beat_t     in_beat,
  input  logic [6:0]            pop_size,
  output logic                  res_valid,
  input  logic                  res_ready,
  output rws_pkg::out_beat_t    res_beat
);
  import rws_pkg::*;

  localparam int IDX_W = $clog2(MAX_POPULATION);
  localparam int TOT_W = MAG_W + IDX_W;
  localparam int CW    = (IDX_W + 1 > POP_W) ? IDX_W + 1 : POP_W;
  localparam logic [CW-1:0]    MAX_C = CW'(MAX_POPULATION);
  localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(MAX_POPULATION - 1);

  eng_state_t state_r, state_nxt;

  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] widx_r, widx_nxt;
  logic [MAG_W-1:0] wmag_r, wmag_nxt;
  logic [15:0]      frac_r, frac_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic [TOT_W-1:0] target_r, target_nxt;
  logic [TOT_W-1:0] cum_r, cum_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [MAG_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [MAG_W-1:0] ram_rdata;

  logic [TOT_W+15:0] prod;
  logic [TOT_W-1:0]  sum;
  logic [CW-1:0]     pop_ext;
  logic [CW-1:0]     act_n;
  logic [IDX_W-1:0]  last_idx;
  logic [MAG_W-1:0]  in_mag;
  logic [CW-1:0]     in_idx_ext;

  rws_fit_ram #(
    .DEPTH (MAX_POPULATION),
    .AW    (IDX_W),
    .DW    (MAG_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // magnitude with the most negative code saturated
  always_comb begin
    if (!in_beat.fitness_value[31]) begin
      in_mag = in_beat.fitness_value[30:0];
    end else if (in_beat.fitness_value == 32'sh8000_0000) begin
      in_mag = {MAG_W{1'b1}};
    end else begin
      in_mag = MAG_W'(-in_beat.fitness_value);
    end
  end

  assign in_idx_ext = CW'(in_beat.entry_index);
  assign pop_ext    = CW'(pop_size);

  always_comb begin
    if (pop_ext == '0) begin
      act_n = CW'(1);
    end else if (pop_ext > MAX_C) begin
      act_n = MAX_C;
    end else begin
      act_n = pop_ext;
    end
  end
  assign last_idx = IDX_W'(act_n - CW'(1));

  assign prod = (TOT_W+16)'(total_r) * (TOT_W+16)'(frac_r);
  assign sum  = cum_r + TOT_W'(ram_rdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      total_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    widx_r   <= widx_nxt;
    wmag_r   <= wmag_nxt;
    frac_r   <= frac_nxt;
    target_r <= target_nxt;
    cum_r    <= cum_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    cur_nxt    = cur_r;
    widx_nxt   = widx_r;
    wmag_nxt   = wmag_r;
    frac_nxt   = frac_r;
    total_nxt  = total_r;
    target_nxt = target_r;
    cum_nxt    = cum_r;
    in_stall   = 1'b1;
    res_valid  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = widx_r;
    ram_wdata  = wmag_r;
    ram_raddr  = cur_r;

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + IDX_W'(1);
        if (clr_r == LAST_ENTRY) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          widx_nxt = IDX_W'(in_beat.entry_index);
          wmag_nxt = in_mag;
          frac_nxt = in_beat.random_fraction;
          if (in_beat.operation == OP_SELECT) begin
            state_nxt = ST_SEL_MUL;
          end else if (in_idx_ext < MAX_C) begin
            // fetch the old magnitude for the total update
            ram_raddr = IDX_W'(in_beat.entry_index);
            state_nxt = ST_WR_UPD;
          end
        end
      end
      ST_WR_UPD: begin
        ram_we    = 1'b1;
        total_nxt = total_r - TOT_W'(ram_rdata) + TOT_W'(wmag_r);
        state_nxt = ST_IDLE;
      end
      ST_SEL_MUL: begin
        target_nxt = prod[TOT_W+15:16];
        cum_nxt    = '0;
        cur_nxt    = '0;
        ram_raddr  = '0;
        state_nxt  = ST_SEL_WALK;
      end
      ST_SEL_WALK: begin
        // a miss at the last entry also picks the last entry
        if (sum >= target_r || cur_r == last_idx) begin
          state_nxt = ST_DONE;
        end else begin
          cum_nxt   = sum;
          cur_nxt   = cur_r + IDX_W'(1);
          ram_raddr = cur_r + IDX_W'(1);
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res_beat.selected_index = 6'(cur_r);
  assign res_beat.total_is_zero  = (total_r == '0);

endmodule

FILE: hw/rtl/roulette_wheel_selector.sv
// Fitness-proportionate selector. Write beats store |fitness| (Q16.16, the most
// negative code saturates) in an on-chip table and keep a running total; select
// beats return the first index whose cumulative magnitude reaches
// total*r/65536, or the last active index if none does. A write reads the old
// entry, then updates the entry and the total; a select multiplies, then walks
// the table, reading one entry per cycle from the table memory. After reset
// the table is zeroed while input is stalled. The result sits in an output
// register so the next item can be taken while it waits. population_size must
// be written only while the block is idle; the block does not enforce this.
module roulette_wheel_selector (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rws_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output rws_pkg::out_beat_t out_beat,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata
);
  import rws_pkg::*;

  logic [POP_W-1:0] pop_size_r;
  logic             out_valid_r;
  out_beat_t        out_beat_r;
  logic             res_valid;
  logic             res_ready;
  out_beat_t        res_beat;

  rws_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .pop_size  (pop_size_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_beat  (res_beat)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pop_size_r  <= POP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        pop_size_r <= cfg_wdata;
      end
      if (res_ready) begin
        out_valid_r <= res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_beat_r <= res_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule
